[hdl/s256bc_pkg.sv]
// Shared types, constants and round functions for the SHA-256 block compression core.
`timescale 1ns / 1ps

package s256bc_pkg;

	localparam int WORD_W       = 32;
	localparam int CHAIN_WORDS  = 8;
	localparam int WINDOW_DEPTH = 16;
	localparam int ROUNDS       = 64;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] state_arr_t;

	// Input request: chaining word load or message word.
	typedef struct packed {
		logic  mode;
		word_t word;
		logic  final_req;
	} in_t;

	// One digest word of the updated chaining state.
	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last;
	} out_t;

	localparam logic MODE_CHAIN = 1'b0;
	localparam logic MODE_MSG   = 1'b1;

	// Schedule window controls.
	typedef struct packed {
		logic shift_in;
		logic roll;
	} sched_ctl_t;

	// Round datapath controls.
	typedef struct packed {
		logic init;
		logic step;
	} round_ctl_t;

	localparam state_arr_t H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic word_t rotr(input word_t v, input int unsigned n);
		rotr = (v >> n) | (v << (WORD_W - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

[hdl/s256bc_sched.sv]
// Rolling 16-word message schedule window with one expansion step per round.
`timescale 1ns / 1ps

module s256bc_sched import s256bc_pkg::*; (
	input  logic       clk,
	input  sched_ctl_t ctl,
	input  word_t      msg_word,
	output word_t      w_cur
);

	word_t win_q [WINDOW_DEPTH];
	word_t w_next;
	word_t shift_word;

	// Next schedule word from the oldest sixteen.
	assign w_next = sig1(win_q[WINDOW_DEPTH-2]) + win_q[WINDOW_DEPTH-7]
		+ sig0(win_q[1]) + win_q[0];
	assign shift_word = ctl.shift_in ? msg_word : w_next;
	assign w_cur = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.shift_in || ctl.roll) begin
			for (int i = 0; i < WINDOW_DEPTH-1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW_DEPTH-1] <= shift_word;
		end
	end

endmodule

[hdl/s256bc_round.sv]
// Working variables a..h and the shared SHA-256 round unit.
`timescale 1ns / 1ps

module s256bc_round import s256bc_pkg::*; (
	input  logic       clk,
	input  round_ctl_t ctl,
	input  state_arr_t chain,
	input  word_t      w_cur,
	input  word_t      k_cur,
	output state_arr_t vars
);

	state_arr_t v_q;
	word_t      ch;
	word_t      maj;
	word_t      t1;
	word_t      t2;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bsig1(v_q[4]) + ch + k_cur + w_cur;
	assign t2  = bsig0(v_q[0]) + maj;
	assign vars = v_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			v_q <= chain;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

[hdl/sha256_block_compress_core.sv]
// Top level: sequencer, chaining state and digest output of the SHA-256 compression core.
// A chaining word or one of the first 15 message words of a block is taken while idle.
// The 16th message word starts all 64 rounds on the single round unit, then the chaining
// addition; req_stall stays high through the rounds and the addition, and through digest output.
// A final block then presents 8 digest words, one per cycle that digest_stall is low.
// Reset sets the chaining words to the SHA-256 initial hash and clears all counters.
`timescale 1ns / 1ps

module sha256_block_compress_core import s256bc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  in_t  req,
	output logic digest_valid,
	input  logic digest_stall,
	output out_t digest
);

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	localparam logic [3:0] MSG_LAST   = 4'(WINDOW_DEPTH - 1);
	localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
	localparam logic [2:0] IDX_LAST   = 3'(CHAIN_WORDS - 1);

	state_t     state_q;
	logic [5:0] round_q;
	logic [3:0] msg_cnt_q;
	logic [2:0] load_cnt_q;
	logic [2:0] emit_idx_q;
	logic       final_q;
	state_arr_t chain_q;

	logic       req_acc;
	logic       msg_acc;
	logic       blk_start;
	logic       dig_acc;
	sched_ctl_t sched_ctl;
	round_ctl_t round_ctl;
	word_t      w_cur;
	state_arr_t vars;

	// Requests are taken only while idle; everything else is the block in flight.
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign msg_acc   = req_acc && (req.mode == MODE_MSG);
	// The 16th message word completes the block and kicks off the rounds.
	assign blk_start = msg_acc && (msg_cnt_q == MSG_LAST);
	assign dig_acc   = digest_valid && !digest_stall;

	assign sched_ctl.shift_in = msg_acc;
	assign sched_ctl.roll     = (state_q == ST_ROUND);
	assign round_ctl.init     = blk_start;
	assign round_ctl.step     = (state_q == ST_ROUND);

	s256bc_sched u_sched (
		.clk      (clk),
		.ctl      (sched_ctl),
		.msg_word (req.word),
		.w_cur    (w_cur)
	);

	s256bc_round u_round (
		.clk   (clk),
		.ctl   (round_ctl),
		.chain (chain_q),
		.w_cur (w_cur),
		.k_cur (ROUND_K[round_q]),
		.vars  (vars)
	);

	// Digest words come straight from the chaining registers, which hold still in EMIT.
	assign digest_valid       = (state_q == ST_EMIT);
	assign digest.digest_word = chain_q[emit_idx_q];
	assign digest.word_index  = emit_idx_q;
	assign digest.last        = (emit_idx_q == IDX_LAST);

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			round_q    <= '0;
			msg_cnt_q  <= '0;
			load_cnt_q <= '0;
			emit_idx_q <= '0;
			final_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.mode == MODE_CHAIN) begin
							// Chaining loads wrap from h back to a.
							load_cnt_q <= load_cnt_q + 3'd1;
						end else begin
							msg_cnt_q <= msg_cnt_q + 4'd1;
						end
					end
					if (blk_start) begin
						final_q <= req.final_req;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					// Advance one round per cycle; the counter wraps back to zero.
					round_q <= round_q + 6'd1;
					if (round_q == ROUND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					emit_idx_q <= '0;
					state_q    <= final_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (dig_acc) begin
						emit_idx_q <= emit_idx_q + 3'd1;
						if (emit_idx_q == IDX_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Chaining state: loaded word by word, then updated once per block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
		end else if (req_acc && (req.mode == MODE_CHAIN)) begin
			chain_q[load_cnt_q] <= req.word;
		end else if (state_q == ST_ADD) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + vars[i];
			end
		end
	end

	// Round counter rests at zero outside the round phase.
	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (round_q == 6'd0))
		else $error("round counter not at zero outside rounds");

	// The add phase follows the last round and nothing else.
	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (round_q == ROUND_LAST) |=> (state_q == ST_ADD))
		else $error("add phase did not follow the last round");

	// No request is taken while digest words are pending.
	a_no_req_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> req_stall)
		else $error("request accepted during digest output");

	// A new block starts with the message counter back at the first slot.
	a_msg_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		blk_start |=> (msg_cnt_q == 4'd0) && (state_q == ST_ROUND))
		else $error("block start did not wrap message counter");

	// Taking the last digest word returns the block to idle.
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		dig_acc && digest.last |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after last digest word");

endmodule

[test/tb_sha256_block_compress_core.sv]
// Self-checking testbench for the SHA-256 block compression core with a digest scoreboard.
`timescale 1ns / 1ps

module tb_sha256_block_compress_core;
	import s256bc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DIRECTED_ITEMS = 25;
	// The last block runs past this count by about ten requests on average.
	localparam int RANDOM_ITEMS = 75;
	// Roughly one block: 64 rounds, chaining add, then eight digest words.
	localparam int TAIL_CYCLES = 100;

	// Round constants and initial hash, kept apart from the design's own copies.
	localparam word_t SHA_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam word_t SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Digest scoreboard: mirrors the chaining state and message window, and holds
	// the digest words still owed by the core, oldest first.
	class digest_scoreboard;
		word_t       chain [8];
		word_t       window [16];
		int unsigned msg_slot;
		int unsigned load_slot;
		out_t        owed_digest [$];
		int unsigned errors;

		function new();
			for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
			for (int i = 0; i < 16; i++) window[i] = '0;
			msg_slot = 0;
			load_slot = 0;
			errors = 0;
		endfunction

		function word_t ror(word_t v, int unsigned n);
			return (v >> n) | (v << (32 - n));
		endfunction

		// Run 64 rounds over the window and fold the result into the chaining words.
		function void compress_block();
			word_t       v [8];
			word_t       x1, x14, w, t1, t2, ch, maj;
			int unsigned s;

			for (int i = 0; i < 8; i++) v[i] = chain[i];
			for (int t = 0; t < 64; t++) begin
				s = t % 16;
				if (t >= 16) begin
					x1 = window[(s + 1) % 16];
					x14 = window[(s + 14) % 16];
					window[s] = window[s]
						+ (ror(x1, 7) ^ ror(x1, 18) ^ (x1 >> 3))
						+ (ror(x14, 17) ^ ror(x14, 19) ^ (x14 >> 10))
						+ window[(s + 9) % 16];
				end
				w = window[s];
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch + SHA_K[t] + w;
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + maj;
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
		endfunction

		// Note one accepted request and queue any digest words it owes.
		function void note_request(in_t r);
			out_t d;

			if (r.mode == MODE_CHAIN) begin
				chain[load_slot] = r.word;
				load_slot = (load_slot + 1) % 8;
				return;
			end
			window[msg_slot] = r.word;
			msg_slot = (msg_slot + 1) % 16;
			if (msg_slot != 0) return;
			compress_block();
			if (!r.final_req) return;
			for (int i = 0; i < 8; i++) begin
				d.digest_word = chain[i];
				d.word_index = 3'(i);
				d.last = (i == 7);
				owed_digest.push_back(d);
			end
		endfunction

		// Check one accepted digest word against the oldest one owed.
		function void check_digest(out_t d);
			out_t e;

			if (owed_digest.size() == 0) begin
				$display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
					$time, d.digest_word, d.word_index, d.last);
				errors++;
				return;
			end
			e = owed_digest.pop_front();
			if (d.digest_word !== e.digest_word) begin
				$display("%0t: digest_word mismatch: expected %h, actual %h",
					$time, e.digest_word, d.digest_word);
				errors++;
			end
			if (d.word_index !== e.word_index) begin
				$display("%0t: word_index mismatch: expected %0d, actual %0d",
					$time, e.word_index, d.word_index);
				errors++;
			end
			if (d.last !== e.last) begin
				$display("%0t: last mismatch: expected %0b, actual %0b",
					$time, e.last, d.last);
				errors++;
			end
		endfunction

		function int unsigned owed();
			return owed_digest.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	in_t  req;
	logic digest_valid;
	logic digest_stall;
	out_t digest;

	digest_scoreboard sb;
	int unsigned      requests_sent;
	int unsigned      cycle_count = 0;
	// High while neither side may idle or stall.
	logic             calm;

	sha256_block_compress_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Stop a hung run: count every edge and bail out at the limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_sha256_block_compress_core: errors");
			$finish;
		end
	end

	// Digest side: check what was accepted at this edge, then pick the next stall.
	// Sampling right at the edge sees the pre-edge values of valid, stall and payload.
	always @(posedge clk) begin
		if (arst_n && digest_valid && !digest_stall)
			sb.check_digest(digest);
		digest_stall <= !calm && ($urandom_range(99) < 23);
	end

	// Offer one request and hold it until the core takes it. Valid stays high after
	// acceptance so back-to-back requests never lower and raise it in one step.
	task automatic send_request(logic m, word_t w, logic f);
		in_t r;
		int  gap;

		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 23) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.mode = m;
		r.word = w;
		r.final_req = f;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		requests_sent++;
	endtask

	// Drop valid and hold off until every owed digest word has come back.
	task automatic wait_digests_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed() != 0) @(posedge clk);
	endtask

	// Bias toward all-zero, all-one and single-bit words now and then.
	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// One well-formed block: optional chaining reload, 16 message words with
	// stray chaining loads and ignored final marks sprinkled in.
	task automatic send_block(logic reload, logic fin);
		for (int i = 0; i < 8 && reload; i++)
			send_request(MODE_CHAIN, pick_word(), 1'($urandom_range(1)));
		for (int i = 0; i < 16; i++) begin
			if ($urandom_range(99) < 8)
				send_request(MODE_CHAIN, pick_word(), 1'($urandom_range(1)));
			if (i == 15)
				send_request(MODE_MSG, pick_word(), fin);
			else
				send_request(MODE_MSG, pick_word(), $urandom_range(99) < 10);
		end
	endtask

	initial begin
		int unsigned seg;

		sb = new();
		requests_sent = 0;
		calm <= 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		digest_stall <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: padded "abc" from the reset chaining value, with a final mark on
		// an early word that must be ignored, digest requested on the last word.
		send_request(MODE_MSG, 32'h61626380, 1'b0);
		send_request(MODE_MSG, 32'h00000000, 1'b0);
		send_request(MODE_MSG, 32'h00000000, 1'b1);
		for (int i = 3; i < 15; i++)
			send_request(MODE_MSG, 32'h00000000, 1'b0);
		send_request(MODE_MSG, 32'h00000018, 1'b1);

		// Directed: nine chaining loads, extremes and final marks on a load; the
		// ninth wraps the load slot back to a. None of these owes a digest.
		send_request(MODE_CHAIN, 32'h00000000, 1'b1);
		send_request(MODE_CHAIN, 32'hFFFFFFFF, 1'b0);
		send_request(MODE_CHAIN, 32'hAAAAAAAA, 1'b1);
		send_request(MODE_CHAIN, 32'h55555555, 1'b0);
		send_request(MODE_CHAIN, 32'h80000000, 1'b0);
		send_request(MODE_CHAIN, 32'h00000001, 1'b1);
		send_request(MODE_CHAIN, 32'hFFFFFFFF, 1'b0);
		send_request(MODE_CHAIN, 32'h00000000, 1'b0);
		send_request(MODE_CHAIN, 32'h12345678, 1'b1);

		// Let the abc digest drain before the random part.
		wait_digests_drained();

		// Random: mostly well-formed blocks, some noise runs. Segments one and two
		// run with no idling on either side; segment three drains first.
		seg = 0;
		while (requests_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			calm <= (seg == 1 || seg == 2);
			if (seg == 3)
				wait_digests_drained();
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_request(1'($urandom_range(1)), pick_word(),
						1'($urandom_range(1)));
			end else begin
				send_block($urandom_range(2) == 0, $urandom_range(99) < 75);
			end
			seg++;
		end
		calm <= 1'b0;

		// Wait out the last digest words, then watch for strays for about a block.
		wait_digests_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.owed() == 0)
			$display("tb_sha256_block_compress_core: clean");
		else
			$display("tb_sha256_block_compress_core: errors");
		$finish;
	end

endmodule
